### rtl/core/pwm_duty_ramp_generator_core_defines.svh
// Assertion macros used by the duty ramp generator checker.
`ifndef PWM_DUTY_RAMP_GENERATOR_CORE_DEFINES_SVH
`define PWM_DUTY_RAMP_GENERATOR_CORE_DEFINES_SVH

// Same-cycle implication, muted while reset is high.
`define PDRG_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, muted while reset is high.
`define PDRG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define PDRG_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/pdrg_pkg.sv
// Types and codes of the PWM duty ramp generator.
package pdrg_pkg;

  localparam int DELAY_BITS     = 16;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  typedef logic [1:0] mode_t;
  typedef logic [1:0] dir_t;
  typedef logic [1:0] req_t;
  typedef logic [CFG_INDEX_BITS-1:0] reg_index_t;

  localparam mode_t MODE_HOLD     = 2'd0;
  localparam mode_t MODE_TRIANGLE = 2'd1;
  localparam mode_t MODE_LINEAR   = 2'd2;

  localparam dir_t DIR_UP   = 2'd0;
  localparam dir_t DIR_DOWN = 2'd1;
  localparam dir_t DIR_NONE = 2'd2;

  localparam req_t REQ_TICK    = 2'd0;
  localparam req_t REQ_ENABLE  = 2'd1;
  localparam req_t REQ_DISABLE = 2'd2;

  localparam reg_index_t REG_MODE        = 3'd0;
  localparam reg_index_t REG_START_LEVEL = 3'd1;
  localparam reg_index_t REG_END_LEVEL   = 3'd2;
  localparam reg_index_t REG_STEP_DELAY  = 3'd3;
  localparam reg_index_t REG_INIT_DIR    = 3'd4;

  typedef struct packed {
    mode_t mode;
    dir_t  init_dir;
  } pdrg_ctrl_t;

endpackage

### rtl/core/pdrg_cfg_regs.sv
// Configuration register file of the PWM duty ramp generator.
module pdrg_cfg_regs
  import pdrg_pkg::*;
#(
  parameter int LEVEL_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  reg_index_t                wr_index,
  input  logic [CFG_DATA_BITS-1:0]  wr_data,
  output pdrg_ctrl_t                ctrl,
  output logic [LEVEL_BITS-1:0]     start_level,
  output logic [LEVEL_BITS-1:0]     end_level,
  output logic [DELAY_BITS-1:0]     step_delay
);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.mode     <= MODE_HOLD;
      ctrl.init_dir <= DIR_UP;
      start_level   <= '0;
      end_level     <= LEVEL_BITS'(255);
      step_delay    <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_MODE:        ctrl.mode     <= mode_t'(wr_data[1:0]);
        REG_START_LEVEL: start_level   <= wr_data[LEVEL_BITS-1:0];
        REG_END_LEVEL:   end_level     <= wr_data[LEVEL_BITS-1:0];
        REG_STEP_DELAY:  step_delay    <= wr_data[DELAY_BITS-1:0];
        REG_INIT_DIR:    ctrl.init_dir <= dir_t'(wr_data[1:0]);
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/pdrg_step.sv
// Next-state logic for one request: enable, disable, or a tick that holds or takes a timed step.
module pdrg_step
  import pdrg_pkg::*;
#(
  parameter int LEVEL_BITS = 8,
  parameter int TIME_BITS  = 32
) (
  input  req_t                   req,
  input  logic [TIME_BITS-1:0]   now,
  input  pdrg_ctrl_t             ctrl,
  input  logic [LEVEL_BITS-1:0]  start_level,
  input  logic [LEVEL_BITS-1:0]  end_level,
  input  logic [DELAY_BITS-1:0]  step_delay,
  input  logic                   enabled,
  input  logic [LEVEL_BITS-1:0]  level,
  input  dir_t                   heading,
  input  logic [TIME_BITS-1:0]   last_time,
  output logic                   enabled_next,
  output logic [LEVEL_BITS-1:0]  level_next,
  output dir_t                   heading_next,
  output logic [TIME_BITS-1:0]   last_time_next
);

  logic [TIME_BITS-1:0]  elapsed;
  logic                  due;
  dir_t                  tri_dir;
  dir_t                  step_dir;
  logic [LEVEL_BITS-1:0] stepped;

  assign elapsed = now - last_time;
  assign due     = elapsed > TIME_BITS'(step_delay);

  // Triangle turns at the end points before stepping.
  always_comb begin
    if (level == end_level) begin
      tri_dir = DIR_DOWN;
    end else if (level == start_level) begin
      tri_dir = DIR_UP;
    end else begin
      tri_dir = heading;
    end
  end

  assign step_dir = (ctrl.mode == MODE_TRIANGLE) ? tri_dir : heading;

  always_comb begin
    case (step_dir)
      DIR_UP:   stepped = (level == end_level) ? '0 : level + 1'b1;
      DIR_DOWN: stepped = (level == '0) ? end_level : level - 1'b1;
      default:  stepped = level;
    endcase
  end

  always_comb begin
    enabled_next   = enabled;
    level_next     = level;
    heading_next   = heading;
    last_time_next = last_time;
    case (req)
      REQ_ENABLE: begin
        enabled_next = 1'b1;
        heading_next = ctrl.init_dir;
        if (ctrl.mode == MODE_LINEAR && ctrl.init_dir != DIR_UP) begin
          level_next = end_level;
        end else begin
          level_next = start_level;
        end
      end
      REQ_DISABLE: begin
        enabled_next = 1'b0;
        level_next   = '0;
      end
      REQ_TICK: begin
        if (enabled) begin
          if (ctrl.mode == MODE_HOLD) begin
            level_next = start_level;
          end else if (due) begin
            last_time_next = now;
            if (ctrl.mode == MODE_TRIANGLE) begin
              heading_next = tri_dir;
              level_next   = stepped;
            end else if (ctrl.mode == MODE_LINEAR) begin
              level_next = stepped;
            end
          end
        end
      end
      default: ;
    endcase
  end

endmodule

### rtl/core/pwm_duty_ramp_generator_core.sv
// Top level of the PWM duty ramp generator: request stage, state and result register.
//
// Channel   Dir  Handshake           Payload
// s_*       in   s_tvalid/s_tready   s_tuser = req_type, s_tdata = now_ms
// m_*       out  m_tvalid/m_tready   m_tdata = duty, is_active
// cfg_*     in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// One beat per cycle while results are taken; a result passes through the request
// register, then through the step logic into the result
// register. The state update and the result load share one edge, so the next
// request sees the new state. A stalled result holds the request stage; reset
// is synchronous and clears the state, configuration and both valid flags.
// Configuration writes are always taken.
module pwm_duty_ramp_generator_core
  import pdrg_pkg::*;
#(
  parameter int LEVEL_BITS = 8,
  parameter int TIME_BITS  = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // requests
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [((TIME_BITS+7)/8)*8-1:0]        s_tdata,   // [TIME_BITS-1:0] now_ms
  input  logic [1:0]                            s_tuser,   // [1:0] req_type
  // results
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [((LEVEL_BITS+8)/8)*8-1:0]       m_tdata,   // [LEVEL_BITS-1:0] duty,
                                                           // [LEVEL_BITS] is_active
  // configuration writes
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0]             cfg_index,
  input  logic [CFG_DATA_BITS-1:0]              cfg_data
);

  localparam int OUT_BITS = ((LEVEL_BITS + 8) / 8) * 8;

  pdrg_ctrl_t            ctrl;
  logic [LEVEL_BITS-1:0] start_level;
  logic [LEVEL_BITS-1:0] end_level;
  logic [DELAY_BITS-1:0] step_delay;

  // Request stage.
  logic                  in_valid;
  req_t                  in_req;
  logic [TIME_BITS-1:0]  in_now;

  // Generator state.
  logic                  enabled;
  logic [LEVEL_BITS-1:0] level;
  dir_t                  heading;
  logic [TIME_BITS-1:0]  last_time;

  logic                  enabled_next;
  logic [LEVEL_BITS-1:0] level_next;
  dir_t                  heading_next;
  logic [TIME_BITS-1:0]  last_time_next;

  // Result register.
  logic                  out_valid;
  logic [LEVEL_BITS-1:0] out_duty;
  logic                  out_active;

  logic                  out_free;
  logic                  advance;

  assign cfg_ready = 1'b1;

  pdrg_cfg_regs #(
    .LEVEL_BITS (LEVEL_BITS)
  ) u_cfg (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (cfg_valid),
    .wr_index    (cfg_index),
    .wr_data     (cfg_data),
    .ctrl        (ctrl),
    .start_level (start_level),
    .end_level   (end_level),
    .step_delay  (step_delay)
  );

  pdrg_step #(
    .LEVEL_BITS (LEVEL_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_step (
    .req            (in_req),
    .now            (in_now),
    .ctrl           (ctrl),
    .start_level    (start_level),
    .end_level      (end_level),
    .step_delay     (step_delay),
    .enabled        (enabled),
    .level          (level),
    .heading        (heading),
    .last_time      (last_time),
    .enabled_next   (enabled_next),
    .level_next     (level_next),
    .heading_next   (heading_next),
    .last_time_next (last_time_next)
  );

  // The result register frees up when empty or when its beat is taken.
  assign out_free = !out_valid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      enabled   <= 1'b0;
      level     <= '0;
      heading   <= DIR_UP;
      last_time <= '0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      // Commit the state together with the result it produces.
      if (advance) begin
        out_valid <= 1'b1;
        enabled   <= enabled_next;
        level     <= level_next;
        heading   <= heading_next;
        last_time <= last_time_next;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_req <= req_t'(s_tuser);
      in_now <= s_tdata[TIME_BITS-1:0];
    end
    if (advance) begin
      out_duty   <= level_next;
      out_active <= enabled_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_BITS'({out_active, out_duty});

endmodule

### rtl/core/pdrg_checker.sv
// Port-level checks of the PWM duty ramp generator, bound to the top level.
`include "pwm_duty_ramp_generator_core_defines.svh"

module pdrg_checker #(
  parameter int LEVEL_BITS = 8,
  parameter int TIME_BITS  = 32
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [((LEVEL_BITS+8)/8)*8-1:0] m_tdata
);

  logic                  active;
  logic [LEVEL_BITS-1:0] duty;

  assign active = m_tdata[LEVEL_BITS];
  assign duty   = m_tdata[LEVEL_BITS-1:0];

  `PDRG_ASSERT_NEXT_ALWAYS(a_reset_drains, clk, rst, !m_tvalid, "result valid after reset")
  `PDRG_ASSERT_NEXT(a_stall_holds, clk, rst, m_tvalid && !m_tready,
                    m_tvalid && $stable(m_tdata), "stalled result changed")
  `PDRG_ASSERT_SAME(a_idle_duty_zero, clk, rst, m_tvalid && !active, duty == '0,
                    "inactive generator reports nonzero duty")
  `PDRG_ASSERT_SAME(a_empty_takes, clk, rst, !m_tvalid, s_tready,
                    "request stalled while result register is empty")

endmodule

bind pwm_duty_ramp_generator_core pdrg_checker #(
  .LEVEL_BITS (LEVEL_BITS),
  .TIME_BITS  (TIME_BITS)
) u_pdrg_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

### tb/sv/tb_pwm_duty_ramp_generator_core.sv
`timescale 1ns / 100ps
// Self-checking testbench of the PWM duty ramp generator core: directed rows, then random phases.
module tb_pwm_duty_ramp_generator_core;
  import pdrg_pkg::*;

  localparam int LEVEL_BITS = 8;
  localparam int TIME_BITS  = 32;

  // Codes the package leaves unnamed; the block must still handle them.
  localparam req_t  REQ_IGNORED = 2'd3;
  localparam mode_t MODE_SPARE  = 2'd3;
  localparam dir_t  DIR_SPARE   = 2'd3;

  // Extra idle time after the last owed result, as margin.
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASES        = 14;
  localparam int PHASE_BEATS   = 70;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] duty;
    logic                  active;
  } duty_out_t;

  typedef enum {ROW_BEAT, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    req_t               req;
    logic [31:0]        now;
    reg_index_t         idx;
    logic [15:0]        data;
    bit                 typed;  // want holds a hand-written result
    duty_out_t          want;
  } plan_row_t;

  // DUT connections; every input known from time zero.
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [31:0] now_ms
  logic [1:0]  s_tuser = '0;   // [1:0] req_type
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // [7:0] duty, [8] is_active
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  // Predicted configuration, held at the block's reset values until written.
  mode_t           cfg_mode  = MODE_HOLD;
  logic [7:0]      cfg_start = 8'd0;
  logic [7:0]      cfg_end   = 8'd255;
  logic [15:0]     cfg_delay = 16'd0;
  dir_t            cfg_dir   = DIR_UP;

  // Predicted generator state.
  logic [7:0]      level        = 8'd0;
  dir_t            heading      = DIR_UP;
  logic [31:0]     last_step_ms = 32'd0;
  bit              running      = 1'b0;

  duty_out_t       duty_q[$];      // results still owed by the block
  plan_row_t       plan[$];
  int              mismatches   = 0;
  int              results_seen = 0;
  int              sink_hold    = 0;
  bit              calm_source  = 1'b0;
  bit              calm_sink    = 1'b0;
  bit              valid_up     = 1'b0;
  bit              cfg_up       = 1'b0;
  logic [31:0]     cursor_ms    = 32'd0;

  pwm_duty_ramp_generator_core #(
    .LEVEL_BITS(LEVEL_BITS),
    .TIME_BITS (TIME_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #2 clk = ~clk;

  // Hard stop in case a handshake never completes.
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic report_mismatch(string what);
    mismatches++;
    $display("[%0t] result beat %0d: %s", $realtime, results_seen, what);
  endtask

  // Mirror a register write into the predicted configuration.
  function automatic void take_write(reg_index_t idx, logic [15:0] data);
    case (idx)
      REG_MODE:        cfg_mode  = data[1:0];
      REG_START_LEVEL: cfg_start = data[7:0];
      REG_END_LEVEL:   cfg_end   = data[7:0];
      REG_STEP_DELAY:  cfg_delay = data;
      REG_INIT_DIR:    cfg_dir   = data[1:0];
      default: ;
    endcase
  endfunction

  // One step along the current heading; wrap at the end level and at zero.
  function automatic void ramp_step();
    if (heading == DIR_UP) begin
      level = (level == cfg_end) ? 8'd0 : level + 8'd1;
    end else if (heading == DIR_DOWN) begin
      level = (level == 8'd0) ? cfg_end : level - 8'd1;
    end
  endfunction

  // Advance the predicted state by one request beat and return the duty it reports.
  function automatic duty_out_t next_duty(req_t req, logic [31:0] now);
    logic [31:0] elapsed;
    duty_out_t   res;
    elapsed = now - last_step_ms;
    if (req == REQ_ENABLE) begin
      running = 1'b1;
      heading = cfg_dir;
      if (cfg_mode == MODE_LINEAR)
        level = (heading == DIR_UP) ? cfg_start : cfg_end;
      else
        level = cfg_start;
    end else if (req == REQ_DISABLE) begin
      running = 1'b0;
      level   = 8'd0;
    end else if (req == REQ_TICK && running) begin
      if (cfg_mode == MODE_HOLD) begin
        level = cfg_start;
      end else if (elapsed > {16'd0, cfg_delay}) begin
        last_step_ms = now;
        if (cfg_mode == MODE_TRIANGLE) begin
          // Turn at either end before stepping.
          if (level == cfg_end)
            heading = DIR_DOWN;
          else if (level == cfg_start)
            heading = DIR_UP;
          ramp_step();
        end else if (cfg_mode == MODE_LINEAR) begin
          ramp_step();
        end
      end
    end
    res.duty   = level;
    res.active = running;
    return res;
  endfunction

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_level();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 8'd0;
    if (r < 30) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [15:0] pick_delay();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 16'($urandom_range(0, 3));
    if (r < 70) return 16'($urandom_range(0, 40));
    if (r < 80) return 16'hFFFF;
    if (r < 90) return 16'd0;
    return 16'($urandom_range(0, 65535));
  endfunction

  // Move the tick time: mostly just past the delay, sometimes short of it,
  // now and then a jump anywhere or up against the 32-bit wrap.
  function automatic logic [31:0] advance_clock();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45)
      cursor_ms = cursor_ms + {16'd0, cfg_delay} + 32'($urandom_range(1, 3));
    else if (r < 65)
      cursor_ms = cursor_ms + 32'($urandom_range(0, cfg_delay));
    else if (r < 88)
      cursor_ms = cursor_ms + 32'($urandom_range(0, 3));
    else if (r < 96)
      cursor_ms = $urandom();
    else
      cursor_ms = 32'hFFFF_FFFF - 32'($urandom_range(0, 4));
    return cursor_ms;
  endfunction

  function automatic plan_row_t beat_row(req_t req, logic [31:0] now);
    plan_row_t row;
    row = '{kind: ROW_BEAT, req: req, now: now, idx: '0, data: '0, typed: 1'b0, want: '0};
    return row;
  endfunction

  function automatic plan_row_t checked_row(req_t req, logic [31:0] now,
                                            logic [7:0] duty, logic active);
    plan_row_t row;
    row = beat_row(req, now);
    row.typed       = 1'b1;
    row.want.duty   = duty;
    row.want.active = active;
    return row;
  endfunction

  function automatic plan_row_t write_row(reg_index_t idx, logic [15:0] data);
    plan_row_t row;
    row = '{kind: ROW_WRITE, req: REQ_TICK, now: '0, idx: idx, data: data,
            typed: 1'b0, want: '0};
    return row;
  endfunction

  // Drop the request valid if it is still up from the last beat.
  task automatic park_source();
    if (valid_up) begin
      s_tvalid <= 1'b0;
      valid_up = 1'b0;
    end
  endtask

  task automatic park_cfg();
    if (cfg_up) begin
      cfg_valid <= 1'b0;
      cfg_up = 1'b0;
    end
  endtask

  // Hold off until every owed result has left the block, then let it settle.
  task automatic settle();
    park_source();
    park_cfg();
    while (duty_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register; hold cfg_valid up for a following write.
  task automatic write_reg(reg_index_t idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_up = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    take_write(idx, data);
  endtask

  // Present one request beat, log its expected result on acceptance, then sometimes idle a while.
  task automatic send_beat(req_t req, logic [31:0] now, bit typed, duty_out_t want);
    duty_out_t predicted;
    int        gap;
    park_cfg();
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= now;
    valid_up = 1'b1;
    do @(posedge clk); while (!s_tready);
    predicted = next_duty(req, now);
    duty_q.push_back(typed ? want : predicted);
    gap = calm_source ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      valid_up = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Result side: check each accepted beat against the oldest expectation,
  // then decide whether to stall the next cycle.
  always @(posedge clk) begin : result_sink
    duty_out_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (duty_q.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = duty_q.pop_front();
        if (m_tdata[LEVEL_BITS-1:0] !== want.duty)
          report_mismatch($sformatf("duty got %0d want %0d",
                                    m_tdata[LEVEL_BITS-1:0], want.duty));
        if (m_tdata[LEVEL_BITS] !== want.active)
          report_mismatch($sformatf("is_active got %b want %b",
                                    m_tdata[LEVEL_BITS], want.active));
      end
    end
    if (sink_hold > 0) begin
      sink_hold--;
      m_tready <= 1'b0;
    end else if (!rst && !calm_sink && $urandom_range(0, 99) < 20) begin
      sink_hold = pick_gap();
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  initial begin : stimulus
    int        r;
    req_t      req;
    logic [31:0] now;
    duty_out_t none;
    none = '0;

    // Directed rows. Typed results are the obvious ones; the rest go through the predictor.
    // Reset state: hold mode, start 0, end 255, no delay, heading up, disabled.
    plan.push_back(checked_row(REQ_TICK, 32'd0, 8'd0, 1'b0));          // tick while disabled
    plan.push_back(checked_row(REQ_IGNORED, 32'hFFFF_FFFF, 8'd0, 1'b0)); // unused request code
    plan.push_back(checked_row(REQ_DISABLE, 32'd0, 8'd0, 1'b0));
    plan.push_back(checked_row(REQ_ENABLE, 32'd0, 8'd0, 1'b1));
    // Hold mode reloads the start level on every tick, with no timing check.
    plan.push_back(write_row(REG_START_LEVEL, 16'd88));
    plan.push_back(checked_row(REQ_TICK, 32'hAAAA_AAAA, 8'd88, 1'b1));
    // Linear ramp up near the top: wrap from the end level to zero.
    plan.push_back(write_row(REG_MODE, 16'(MODE_LINEAR)));
    plan.push_back(write_row(REG_START_LEVEL, 16'd253));
    plan.push_back(write_row(REG_END_LEVEL, 16'd255));
    plan.push_back(write_row(REG_STEP_DELAY, 16'd0));
    plan.push_back(write_row(REG_INIT_DIR, 16'(DIR_UP)));
    plan.push_back(checked_row(REQ_ENABLE, 32'd1, 8'd253, 1'b1));
    plan.push_back(beat_row(REQ_TICK, 32'd1));
    plan.push_back(beat_row(REQ_TICK, 32'd1));          // no elapsed time, no step
    plan.push_back(beat_row(REQ_TICK, 32'd2));
    plan.push_back(beat_row(REQ_TICK, 32'd3));
    // Largest delay, ramping down: elapsed must exceed it strictly, and across the time wrap.
    plan.push_back(write_row(REG_STEP_DELAY, 16'hFFFF));
    plan.push_back(write_row(REG_INIT_DIR, 16'(DIR_DOWN)));
    plan.push_back(checked_row(REQ_ENABLE, 32'hFFFF_FFF0, 8'd255, 1'b1));
    plan.push_back(beat_row(REQ_TICK, 32'd65538));
    plan.push_back(beat_row(REQ_TICK, 32'd65539));
    plan.push_back(beat_row(REQ_TICK, 32'hFFFF_FFFF));
    plan.push_back(beat_row(REQ_TICK, 32'd5));
    // Start above the end level: the increment wraps past the top of the byte.
    plan.push_back(write_row(REG_STEP_DELAY, 16'd0));
    plan.push_back(write_row(REG_START_LEVEL, 16'd255));
    plan.push_back(write_row(REG_END_LEVEL, 16'd10));
    plan.push_back(write_row(REG_INIT_DIR, 16'(DIR_UP)));
    plan.push_back(checked_row(REQ_ENABLE, 32'd6, 8'd255, 1'b1));
    plan.push_back(beat_row(REQ_TICK, 32'd7));
    // Triangle bouncing between two adjacent turning points.
    plan.push_back(write_row(REG_MODE, 16'(MODE_TRIANGLE)));
    plan.push_back(write_row(REG_START_LEVEL, 16'd254));
    plan.push_back(write_row(REG_END_LEVEL, 16'd255));
    plan.push_back(checked_row(REQ_ENABLE, 32'd8, 8'd254, 1'b1));
    plan.push_back(beat_row(REQ_TICK, 32'd9));
    plan.push_back(beat_row(REQ_TICK, 32'd10));
    plan.push_back(beat_row(REQ_TICK, 32'd11));
    // Unused mode code: enable loads the start level, ticks never move it.
    plan.push_back(write_row(REG_MODE, 16'(MODE_SPARE)));
    plan.push_back(checked_row(REQ_ENABLE, 32'd12, 8'd254, 1'b1));
    plan.push_back(beat_row(REQ_TICK, 32'd13));
    // Unused direction code in linear mode: loads the end level and never moves.
    plan.push_back(write_row(REG_MODE, 16'(MODE_LINEAR)));
    plan.push_back(write_row(REG_INIT_DIR, 16'(DIR_SPARE)));
    plan.push_back(checked_row(REQ_ENABLE, 32'd14, 8'd255, 1'b1));
    plan.push_back(beat_row(REQ_TICK, 32'd15));
    plan.push_back(write_row(REG_INIT_DIR, 16'(DIR_NONE)));
    plan.push_back(beat_row(REQ_ENABLE, 32'd16));
    plan.push_back(checked_row(REQ_DISABLE, 32'd18, 8'd0, 1'b0));

    // Hold reset once, then release it.
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed rows; let the block drain before each group of writes.
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        if (i == 0 || plan[i-1].kind == ROW_BEAT) settle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_beat(plan[i].req, plan[i].now, plan[i].typed, plan[i].want);
      end
    end

    // Random phases: reconfigure while idle, then mostly enable-and-tick runs
    // with some stray enables, disables and unused codes mixed in.
    for (int p = 0; p < PHASES; p++) begin
      settle();
      r = $urandom_range(0, 9);
      if (r == 0)     write_reg(REG_MODE, 16'(MODE_HOLD));
      else if (r < 5) write_reg(REG_MODE, 16'(MODE_TRIANGLE));
      else if (r < 9) write_reg(REG_MODE, 16'(MODE_LINEAR));
      else            write_reg(REG_MODE, 16'(MODE_SPARE));
      write_reg(REG_START_LEVEL, {8'd0, pick_level()});
      write_reg(REG_END_LEVEL, {8'd0, pick_level()});
      write_reg(REG_STEP_DELAY, pick_delay());
      r = $urandom_range(0, 99);
      if (r < 40)      write_reg(REG_INIT_DIR, 16'(DIR_UP));
      else if (r < 80) write_reg(REG_INIT_DIR, 16'(DIR_DOWN));
      else if (r < 92) write_reg(REG_INIT_DIR, 16'(DIR_NONE));
      else             write_reg(REG_INIT_DIR, 16'(DIR_SPARE));

      // Some phases run without any idling on one or both sides.
      calm_source = ($urandom_range(0, 3) == 0);
      calm_sink   = ($urandom_range(0, 3) == 0);

      for (int b = 0; b < PHASE_BEATS; b++) begin
        r = $urandom_range(0, 99);
        if (b == 0 || (r >= 80 && r < 87)) req = REQ_ENABLE;
        else if (r >= 87 && r < 93)        req = REQ_DISABLE;
        else if (r >= 93 && r < 96)        req = REQ_IGNORED;
        else                               req = REQ_TICK;
        now = (req == REQ_TICK) ? advance_clock() : $urandom();
        send_beat(req, now, 1'b0, none);
      end
    end
    calm_source = 1'b0;
    calm_sink   = 1'b0;

    // Wait out every owed result, then give the verdict.
    settle();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/pdrg_pkg.sv
rtl/core/pdrg_cfg_regs.sv
rtl/core/pdrg_step.sv
rtl/core/pwm_duty_ramp_generator_core.sv
rtl/core/pdrg_checker.sv
tb/sv/tb_pwm_duty_ramp_generator_core.sv
